### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the retry backoff scheduler checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/rbs_pkg.sv
// ----------------------------------------------------------------------------
// rbs_pkg
// Types and constants shared by the retry backoff scheduler modules.
// ----------------------------------------------------------------------------
package rbs_pkg;

   // Default tick counter width.
   localparam int TICK_BITS_DEFAULT = 32;

   // Field widths fixed by the interface.
   localparam int FUNC_W     = 2;
   localparam int TICK_IN_W  = 32;
   localparam int MIN_RETRY_W = 16;
   localparam int MAX_RETRY_W = 31;
   localparam int DELAY_W    = 31;
   localparam int CSR_DATA_W = 31;
   localparam int CSR_INDEX_W = 1;

   // Event codes.
   localparam logic [FUNC_W-1:0] FUNC_INIT    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REQUEST = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TRY     = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_FINISH  = 2'd3;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_RETRY = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RETRY = 1'd1;

   // Register reset values.
   localparam logic [MIN_RETRY_W-1:0] MIN_RETRY_RESET = 16'd1;
   localparam logic [MAX_RETRY_W-1:0] MAX_RETRY_RESET = 31'd64;

   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic [TICK_IN_W-1:0] current_tick;
      logic                 transport_can_begin;
      logic                 snapshot_sent;
   } req_type;

   typedef struct packed {
      logic began;
      logic pending_now;
      logic active_now;
      logic in_flight_now;
   } rsp_type;

   typedef struct packed {
      logic pending;
      logic attempt_active;
      logic transport_busy;
   } flags_type;

endpackage

### rtl/core/rbs_step.sv
// ----------------------------------------------------------------------------
// rbs_step
// Next-state and response logic for one scheduler event.
// ----------------------------------------------------------------------------
module rbs_step #(
   parameter int TICK_BITS = rbs_pkg::TICK_BITS_DEFAULT
) (
   input  rbs_pkg::req_type                    req,
   input  rbs_pkg::flags_type                  flags,
   input  logic [TICK_BITS-1:0]                next_tick,
   input  logic [rbs_pkg::DELAY_W-1:0]         delay,
   input  logic [rbs_pkg::MIN_RETRY_W-1:0]     min_retry,
   input  logic [rbs_pkg::MAX_RETRY_W-1:0]     max_retry,
   output rbs_pkg::flags_type                  flags_in,
   output logic [TICK_BITS-1:0]                next_tick_in,
   output logic [rbs_pkg::DELAY_W-1:0]         delay_in,
   output rbs_pkg::rsp_type                    rsp
);

   logic [TICK_BITS-1:0]           now;
   logic [TICK_BITS-1:0]           since;
   logic                           reached;
   logic [rbs_pkg::DELAY_W:0]      twice;
   logic [rbs_pkg::DELAY_W-1:0]    doubled;
   logic [rbs_pkg::DELAY_W-1:0]    min_delay;
   logic [TICK_BITS-1:0]           retry_tick;
   logic [TICK_BITS-1:0]           holdoff_tick;
   logic                           began;

   assign now       = TICK_BITS'(req.current_tick);
   assign min_delay = rbs_pkg::DELAY_W'(min_retry);

   // The deadline is reached when the distance past it, taken modulo the
   // tick range, lies in the lower half of that range.
   assign since   = now - next_tick;
   assign reached = !since[TICK_BITS-1];

   // Capped doubling; a delay already at or above the cap is kept.
   assign twice = {delay, 1'b0};
   always_comb begin
      if (delay < max_retry) begin
         if (twice > {1'b0, max_retry}) begin
            doubled = max_retry;
         end else begin
            doubled = twice[rbs_pkg::DELAY_W-1:0];
         end
      end else begin
         doubled = delay;
      end
   end

   assign retry_tick   = now + TICK_BITS'(delay);
   assign holdoff_tick = now + TICK_BITS'(min_retry);

   always_comb begin
      flags_in     = flags;
      next_tick_in = next_tick;
      delay_in     = delay;
      began        = 1'b0;
      unique case (req.func)
         rbs_pkg::FUNC_INIT: begin
            next_tick_in = now;
            delay_in     = min_delay;
            flags_in     = '0;
         end
         rbs_pkg::FUNC_REQUEST: begin
            flags_in.pending = 1'b1;
         end
         rbs_pkg::FUNC_TRY: begin
            if (flags.pending && !flags.attempt_active && reached) begin
               if (!req.transport_can_begin) begin
                  flags_in.transport_busy = 1'b1;
                  next_tick_in            = retry_tick;
                  delay_in                = doubled;
               end else begin
                  flags_in.transport_busy = 1'b0;
                  flags_in.attempt_active = 1'b1;
                  began                   = 1'b1;
               end
            end
         end
         rbs_pkg::FUNC_FINISH: begin
            if (flags.attempt_active) begin
               flags_in.attempt_active = 1'b0;
               flags_in.transport_busy = 1'b1;
               if (req.snapshot_sent) begin
                  flags_in.pending = 1'b0;
                  delay_in         = min_delay;
                  next_tick_in     = holdoff_tick;
               end else begin
                  flags_in.pending = 1'b1;
                  next_tick_in     = retry_tick;
                  delay_in         = doubled;
               end
            end
         end
      endcase
   end

   assign rsp.began         = began;
   assign rsp.pending_now   = flags_in.pending;
   assign rsp.active_now    = flags_in.attempt_active;
   assign rsp.in_flight_now = flags_in.transport_busy;

endmodule

### rtl/core/retry_backoff_scheduler_core.sv
// ----------------------------------------------------------------------------
// retry_backoff_scheduler_core
// Capped exponential backoff retry scheduler, one event per request.
// ----------------------------------------------------------------------------
// Each request carries one event (initialize, request, try begin or finish)
// and produces exactly one response with the began flag and the pending,
// active and in-flight flags as they stand after the event. The block
// accepts one request per clock cycle while the response side does not
// stall. A request is held in the input register; when the response
// register is free, one pass through the step logic updates the scheduler
// state and loads the response register, which then offers the response.
// The step logic holds the tick adds for the retry and holdoff deadlines,
// one wrap-aware deadline compare and the capped doubling of the retry
// delay. Back-pressure on the response side stalls both stages. The input
// register keeps taking requests while it is empty or while the stage ahead
// of it drains.
// The configuration registers are meant to be written while no request is
// in the block; a new minimum delay reaches the retry delay only at the next
// initialize or successful finish.
module retry_backoff_scheduler_core #(
   parameter int TICK_BITS = rbs_pkg::TICK_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rbs_pkg::req_type                    req_payload,
   // Response channel.
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rbs_pkg::rsp_type                    rsp_payload,
   // Configuration write port.
   input  logic                                csr_write,
   input  logic [rbs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rbs_pkg::CSR_DATA_W-1:0]      csr_data
);

   // Configuration registers.
   logic [rbs_pkg::MIN_RETRY_W-1:0] min_retry_ff;
   logic [rbs_pkg::MIN_RETRY_W-1:0] min_retry_in;
   logic [rbs_pkg::MAX_RETRY_W-1:0] max_retry_ff;
   logic [rbs_pkg::MAX_RETRY_W-1:0] max_retry_in;

   // Scheduler state.
   rbs_pkg::flags_type              flags_ff;
   rbs_pkg::flags_type              flags_in;
   logic [TICK_BITS-1:0]            next_tick_ff;
   logic [TICK_BITS-1:0]            next_tick_in;
   logic [rbs_pkg::DELAY_W-1:0]     delay_ff;
   logic [rbs_pkg::DELAY_W-1:0]     delay_in;

   // Input stage and response stage.
   logic                            s1_valid_ff;
   logic                            s1_valid_in;
   rbs_pkg::req_type                s1_req_ff;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   rbs_pkg::rsp_type                rsp_ff;
   rbs_pkg::rsp_type                step_rsp;

   logic                            out_free;
   logic                            advance;
   logic                            req_take;

   // The response register can load when it is empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !out_free);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   rbs_step #(
      .TICK_BITS (TICK_BITS)
   ) u_rbs_step (
      .req          (s1_req_ff),
      .flags        (flags_ff),
      .next_tick    (next_tick_ff),
      .delay        (delay_ff),
      .min_retry    (min_retry_ff),
      .max_retry    (max_retry_ff),
      .flags_in     (flags_in),
      .next_tick_in (next_tick_in),
      .delay_in     (delay_in),
      .rsp          (step_rsp)
   );

   // Register writes; an index outside the register list has no effect.
   always_comb begin
      min_retry_in = min_retry_ff;
      max_retry_in = max_retry_ff;
      if (csr_write) begin
         unique case (csr_index)
            rbs_pkg::CSR_MIN_RETRY: begin
               min_retry_in = csr_data[rbs_pkg::MIN_RETRY_W-1:0];
            end
            rbs_pkg::CSR_MAX_RETRY: begin
               max_retry_in = csr_data[rbs_pkg::MAX_RETRY_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_retry_ff <= rbs_pkg::MIN_RETRY_RESET;
         max_retry_ff <= rbs_pkg::MAX_RETRY_RESET;
         flags_ff     <= '0;
         next_tick_ff <= '0;
         delay_ff     <= rbs_pkg::DELAY_W'(rbs_pkg::MIN_RETRY_RESET);
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         min_retry_ff <= min_retry_in;
         max_retry_ff <= max_retry_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // State moves only when the event in the input stage is retired.
         if (advance) begin
            flags_ff     <= flags_in;
            next_tick_ff <= next_tick_in;
            delay_ff     <= delay_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### rtl/core/rbs_checker.sv
// ----------------------------------------------------------------------------
// rbs_checker
// Port-level checks for the retry backoff scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbs_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input rbs_pkg::req_type  req_payload,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input rbs_pkg::rsp_type  rsp_payload
);

   logic req_wait;
   logic rsp_held;
   logic began_ok;
   logic active_ok;

   assign req_wait  = req_valid && !req_ready;
   assign rsp_held  = rsp_valid && !rsp_ready;
   // A started attempt leaves the transport idle and the attempt active.
   assign began_ok  = rsp_payload.active_now && !rsp_payload.in_flight_now;
   // An active attempt always has work pending behind it.
   assign active_ok = !rsp_payload.active_now || rsp_payload.pending_now;

   `ASSERT_IMPLIES(a_began_active, clock, reset, rsp_valid && rsp_payload.began, began_ok)
   `ASSERT_IMPLIES(a_active_pending, clock, reset, rsp_valid, active_ok)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_payload))
   `ASSERT_NEXT(a_req_hold, clock, reset, req_wait, req_valid && $stable(req_payload))

endmodule

bind retry_backoff_scheduler_core rbs_checker u_rbs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

### sim/backoff_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// backoff_checker
// Watches the request, response and register ports of the retry backoff
// scheduler, predicts each response and compares it with what comes out.
// ----------------------------------------------------------------------------
module backoff_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  rbs_pkg::req_type                    req_payload,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  rbs_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_write,
   input  logic [rbs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rbs_pkg::CSR_DATA_W-1:0]      csr_data,
   output int                                  fail_count,
   output int                                  outstanding,
   output int                                  checked_count,
   output int                                  began_count
);
   import rbs_pkg::*;

   // Shadow copy of the registers and of the scheduler state.
   logic [MIN_RETRY_W-1:0] min_ticks;
   logic [MAX_RETRY_W-1:0] max_ticks;
   logic [31:0]            deadline;
   logic [DELAY_W-1:0]     delay;
   logic                   pending;
   logic                   active;
   logic                   busy;

   // Predicted responses, oldest first.
   rsp_type predicted_rsp[$];

   // The deadline counts as reached when the tick is less than half a wrap past it.
   function automatic logic deadline_met(input logic [31:0] now, input logic [31:0] target);
      logic [31:0] diff;
      diff = now - target;
      return (now == target) || (diff < 32'h8000_0000);
   endfunction

   task automatic backoff_from(input logic [31:0] now);
      logic [31:0] doubled;
      deadline = now + {1'b0, delay};
      if (delay < max_ticks) begin
         doubled = {delay, 1'b0};
         delay = (doubled > {1'b0, max_ticks}) ? max_ticks : doubled[DELAY_W-1:0];
      end
   endtask

   task automatic apply_event(input req_type ev, output rsp_type res);
      res = '0;
      case (ev.func)
         FUNC_INIT: begin
            deadline = ev.current_tick;
            delay    = {15'd0, min_ticks};
            pending  = 1'b0;
            active   = 1'b0;
            busy     = 1'b0;
         end
         FUNC_REQUEST: begin
            pending = 1'b1;
         end
         FUNC_TRY: begin
            if (pending && !active && deadline_met(ev.current_tick, deadline)) begin
               if (!ev.transport_can_begin) begin
                  busy = 1'b1;
                  backoff_from(ev.current_tick);
               end else begin
                  busy      = 1'b0;
                  active    = 1'b1;
                  res.began = 1'b1;
               end
            end
         end
         FUNC_FINISH: begin
            if (active) begin
               active = 1'b0;
               busy   = 1'b1;
               if (ev.snapshot_sent) begin
                  pending  = 1'b0;
                  delay    = {15'd0, min_ticks};
                  deadline = ev.current_tick + {16'd0, min_ticks};
               end else begin
                  pending = 1'b1;
                  backoff_from(ev.current_tick);
               end
            end
         end
      endcase
      res.pending_now   = pending;
      res.active_now    = active;
      res.in_flight_now = busy;
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type next_rsp;
      if (reset) begin
         min_ticks = MIN_RETRY_RESET;
         max_ticks = MAX_RETRY_RESET;
         deadline  = '0;
         delay     = {15'd0, MIN_RETRY_RESET};
         pending   = 1'b0;
         active    = 1'b0;
         busy      = 1'b0;
         predicted_rsp.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_MIN_RETRY: min_ticks = csr_data[MIN_RETRY_W-1:0];
               CSR_MAX_RETRY: max_ticks = csr_data[MAX_RETRY_W-1:0];
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsp.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: response with none predicted: began=%b pending=%b active=%b in_flight=%b",
                           $time, rsp_payload.began, rsp_payload.pending_now,
                           rsp_payload.active_now, rsp_payload.in_flight_now);
               fail_count++;
            end else begin
               want = predicted_rsp.pop_front();
               if (rsp_payload.began !== want.began ||
                   rsp_payload.pending_now !== want.pending_now ||
                   rsp_payload.active_now !== want.active_now ||
                   rsp_payload.in_flight_now !== want.in_flight_now) begin
                  if (fail_count < 10)
                     $display("%0t: response %0d: expected began=%b pending=%b active=%b in_flight=%b, got %b %b %b %b",
                              $time, checked_count, want.began, want.pending_now, want.active_now,
                              want.in_flight_now, rsp_payload.began, rsp_payload.pending_now,
                              rsp_payload.active_now, rsp_payload.in_flight_now);
                  fail_count++;
               end
            end
            checked_count++;
            if (rsp_payload.began === 1'b1)
               began_count++;
         end
         if (req_valid && req_ready) begin
            apply_event(req_payload, next_rsp);
            predicted_rsp.push_back(next_rsp);
         end
      end
      outstanding = predicted_rsp.size();
   end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the retry backoff scheduler core: a directed walk
// through deadline, backoff and cap corner cases, then random event streams
// under several register settings, some with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
   import rbs_pkg::*;

   // Generous bound: roughly 650 requests, each worst case a long sender gap
   // plus a long response stall plus the pass through the input and response
   // registers, taken several times over.
   localparam int CYCLE_LIMIT = 400000;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_write   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_data    = '0;

   int fail_count;
   int outstanding;
   int checked_count;
   int began_count;

   int          cycles         = 0;
   int          sent_count     = 0;
   int          settings_count = 0;
   int          stall_left     = 0;
   // While quiet is set neither side inserts gaps.
   bit          quiet          = 1'b0;
   // Running tick value that the random event streams advance.
   logic [31:0] tick_now       = '0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   retry_backoff_scheduler_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   backoff_checker scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .checked_count (checked_count),
      .began_count   (began_count)
   );

   // Most gaps are short; about one in ten is long.
   function automatic int gap_length();
      if ($urandom_range(0, 9) != 0)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic req_type make_event(input logic [FUNC_W-1:0] func,
                                          input logic [31:0] tick,
                                          input logic can_begin,
                                          input logic sent);
      req_type ev;
      ev.func                = func;
      ev.current_tick        = tick;
      ev.transport_can_begin = can_begin;
      ev.snapshot_sent       = sent;
      return ev;
   endfunction

   // The response side stalls at random, a new decision at each falling edge while no stall runs.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!quiet && $urandom_range(0, 5) == 0)
            stall_left <= gap_length();
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("retry_backoff_scheduler_core: mismatch");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   // Valid is only lowered when a gap is taken, so back-to-back requests keep
   // it high with a single assignment per time step.
   task automatic send(input req_type ev);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 3) == 0)
         gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= ev;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      @(negedge clock);
   endtask

   // Stop sending until every predicted response has come back. Every request
   // makes a response, so an empty prediction queue means an empty pipeline;
   // the extra cycles are margin.
   task automatic drain();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_limits(input logic [MIN_RETRY_W-1:0] min_value,
                             input logic [MAX_RETRY_W-1:0] max_value);
      write_reg(CSR_MIN_RETRY, {15'd0, min_value});
      write_reg(CSR_MAX_RETRY, max_value);
      settings_count++;
   endtask

   // One random phase. Most requests form plausible event streams: ticks
   // creep forward by up to step_max so deadlines are met now and then, with
   // occasional jumps to an arbitrary tick. About one request in twelve is
   // pure noise with every field random.
   task automatic run_phase(input logic [MIN_RETRY_W-1:0] min_value,
                            input logic [MAX_RETRY_W-1:0] max_value,
                            input int step_max, input int items, input bit reinit);
      req_type          ev;
      logic [FUNC_W-1:0] func;
      int               pick;
      drain();
      set_limits(min_value, max_value);
      // Every other phase runs without gaps on either side.
      quiet = (settings_count % 2 == 0);
      if (reinit) begin
         tick_now = $urandom();
         send(make_event(FUNC_INIT, tick_now, 1'b0, 1'b0));
      end
      repeat (items) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            ev.func                = FUNC_W'($urandom_range(0, 3));
            ev.current_tick        = $urandom();
            ev.transport_can_begin = 1'($urandom_range(0, 1));
            ev.snapshot_sent       = 1'($urandom_range(0, 1));
         end else begin
            if ($urandom_range(0, 99) < 3)
               tick_now = $urandom();
            else
               tick_now = tick_now + $urandom_range(0, step_max);
            pick = $urandom_range(0, 99);
            if (pick < 5)
               func = FUNC_INIT;
            else if (pick < 22)
               func = FUNC_REQUEST;
            else if (pick < 65)
               func = FUNC_TRY;
            else
               func = FUNC_FINISH;
            ev = make_event(func, tick_now, $urandom_range(0, 3) != 0,
                            1'($urandom_range(0, 1)));
         end
         send(ev);
      end
   endtask

   initial begin : stimulus
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part under the reset limits (minimum 1, maximum 64); the
      // deadline starts at tick zero.
      quiet = 1'b1;
      // Try begin with nothing pending is blocked.
      send(make_event(FUNC_TRY, 32'h0000_0000, 1'b1, 1'b0));
      // Finish with no attempt active changes nothing.
      send(make_event(FUNC_FINISH, 32'h0000_0003, 1'b0, 1'b1));
      send(make_event(FUNC_REQUEST, 32'h0000_0004, 1'b0, 1'b0));
      // One tick behind the deadline, and exactly half a wrap past it: both
      // count as not reached.
      send(make_event(FUNC_TRY, 32'hFFFF_FFFF, 1'b1, 1'b0));
      send(make_event(FUNC_TRY, 32'h8000_0000, 1'b1, 1'b0));
      // Just under half a wrap is reached; the transport refuses, so a retry
      // is scheduled and the delay doubles.
      send(make_event(FUNC_TRY, 32'h7FFF_FFFF, 1'b0, 1'b0));
      // Tick equal to the deadline begins an attempt.
      send(make_event(FUNC_TRY, 32'h8000_0000, 1'b1, 1'b0));
      // Failed finish backs off again.
      send(make_event(FUNC_FINISH, 32'h8000_0002, 1'b0, 1'b0));
      send(make_event(FUNC_TRY, 32'h8000_0004, 1'b0, 1'b0));
      send(make_event(FUNC_TRY, 32'h8000_0010, 1'b1, 1'b0));
      // Successful finish clears pending and restores the minimum delay.
      send(make_event(FUNC_FINISH, 32'h8000_0011, 1'b1, 1'b1));
      // Retry deadline that wraps past the top of the tick range.
      send(make_event(FUNC_INIT, 32'hFFFF_FFFE, 1'b1, 1'b1));
      send(make_event(FUNC_REQUEST, 32'hFFFF_FFFE, 1'b0, 1'b0));
      send(make_event(FUNC_TRY, 32'hFFFF_FFFF, 1'b0, 1'b0));
      send(make_event(FUNC_TRY, 32'h0000_0000, 1'b1, 1'b0));
      send(make_event(FUNC_FINISH, 32'h0000_0001, 1'b1, 1'b0));

      // Zero delay and zero cap: retries are due at once and never grow.
      drain();
      set_limits(16'd0, 31'd0);
      send(make_event(FUNC_INIT, 32'h1234_5678, 1'b0, 1'b0));
      send(make_event(FUNC_REQUEST, 32'h1234_5678, 1'b0, 1'b0));
      send(make_event(FUNC_TRY, 32'h1234_5678, 1'b0, 1'b0));
      send(make_event(FUNC_TRY, 32'h1234_5678, 1'b1, 1'b0));
      send(make_event(FUNC_FINISH, 32'h1234_5678, 1'b0, 1'b0));

      // The delay reaches the cap, then the cap is lowered below it: the delay
      // must stay where it is, which shows in the next deadline.
      drain();
      set_limits(16'd40, 31'd100);
      send(make_event(FUNC_INIT, 32'd100, 1'b0, 1'b0));
      send(make_event(FUNC_REQUEST, 32'd100, 1'b0, 1'b0));
      send(make_event(FUNC_TRY, 32'd100, 1'b0, 1'b0));
      send(make_event(FUNC_TRY, 32'd140, 1'b0, 1'b0));
      drain();
      set_limits(16'd40, 31'd50);
      send(make_event(FUNC_TRY, 32'd220, 1'b0, 1'b0));
      send(make_event(FUNC_TRY, 32'd319, 1'b1, 1'b0));
      send(make_event(FUNC_TRY, 32'd320, 1'b1, 1'b0));

      // Random phases; some keep the state of the previous phase so that a
      // changed cap or minimum meets a delay that is already in place.
      run_phase(16'd1, 31'd64, 40, 100, 1'b1);
      run_phase(16'd0, 31'd0, 4, 80, 1'b0);
      run_phase(16'hFFFF, 31'h7FFF_FFFF, 32'h0100_0000, 100, 1'b1);
      run_phase(16'd3, 31'd20, 30, 100, 1'b1);
      run_phase(16'd3, 31'd5, 10, 80, 1'b0);
      run_phase(16'd0, 31'h7FFF_FFFF, 8, 70, 1'b1);
      begin : random_limits
         logic [MIN_RETRY_W-1:0] min_value;
         logic [MAX_RETRY_W-1:0] max_value;
         min_value = MIN_RETRY_W'($urandom_range(0, 300));
         max_value = MAX_RETRY_W'($urandom_range(0, 2000));
         run_phase(min_value, max_value, max_value / 8 + 2, 70, 1'b1);
      end

      drain();
      repeat (10) @(negedge clock);

      $display("Sent %0d requests across %0d register settings with random stalls.",
               sent_count, settings_count);
      $display("Checked %0d responses, %0d of them starting an attempt.",
               checked_count, began_count);
      if (fail_count == 0 && outstanding == 0)
         $display("retry_backoff_scheduler_core: match");
      else
         $display("retry_backoff_scheduler_core: mismatch");
      $finish;
   end

endmodule

### files.f
+incdir+rtl/core
rtl/core/rbs_pkg.sv
rtl/core/rbs_step.sv
rtl/core/retry_backoff_scheduler_core.sv
rtl/core/rbs_checker.sv
sim/backoff_checker.sv
sim/tb.sv
